>>> design/layer_normalization_unit_macros.svh
// assertion macros shared by the checker
`ifndef LAYER_NORMALIZATION_UNIT_MACROS_SVH
`define LAYER_NORMALIZATION_UNIT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define LNU_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("layer norm check failed");

// next-cycle implication, ignored while reset is high
`define LNU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("layer norm check failed");

`endif

>>> design/lnu_pkg.sv
`default_nettype none

package lnu_pkg;

   localparam int MAX_LEN = 1024;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int LEN_W   = ADDR_W + 1;
   localparam int DATA_W  = 32;
   localparam int ROW_W   = 3 * DATA_W;
   localparam int SUM_W   = 43;
   localparam int SQ_W    = 75;
   localparam int DIV_W   = 75;
   localparam int DVS_W   = LEN_W + 1;
   localparam int CNT_W   = 7;
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int RND_W   = 51;
   localparam int WIDE_W  = 52;

   localparam logic CSR_ROW_LENGTH = 1'b0;
   localparam logic CSR_EPSILON    = 1'b1;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NOT_READY = 1'b1;

   localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = LEN_W'(768);
   localparam logic [31:0]      EPSILON_RESET    = 32'd42950;

   typedef logic signed [DATA_W-1:0] word_type;

   // shift right 16 with rounding half away from zero
   function automatic logic signed [RND_W-1:0] round16(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] r;
      mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      r   = (mag + PROD_W'(32768)) >> 16;
      round16 = p[PROD_W-1] ? -$signed(r[RND_W-1:0]) : $signed(r[RND_W-1:0]);
   endfunction

   // clamp to the 32-bit signed range
   function automatic word_type sat32(input logic signed [WIDE_W-1:0] v);
      if (v > WIDE_W'(64'sd2147483647)) begin
         sat32 = 32'sh7fffffff;
      end else if (v < -WIDE_W'(64'sd2147483648)) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[DATA_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

>>> design/lnu_ram.sv
`default_nettype none

module lnu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> design/layer_normalization_unit.sv
// layer normalization of one token row. loads (func 0) store sample, gain and
// offset; the load that completes the row starts the row statistics: a sum
// pass over the buffer, a bit-serial mean division, a squared-deviation pass,
// a bit-serial variance division and a 32-step inverse square root, their
// length set by the single buffer read port and the shared 33x33 multiplier.
// busy is high meanwhile. a drain (func 1) on a ready row goes busy and
// passes through the multiplier twice; a drain before the row is ready
// answers status not_ready on the next cycle without going busy.
// each result is on the rsp_ ports for exactly one cycle with rsp_valid set
// and is transferred at the end of that cycle: the receiver cannot stall it.
// loads on a full or ready row are dropped. csr writes belong to idle time.
`default_nettype none

module layer_normalization_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_func,
   input  wire logic signed [31:0]           req_sample,
   input  wire logic signed [31:0]           req_gain,
   input  wire logic signed [31:0]           req_offset,
   output logic                              rsp_valid,
   output logic signed [31:0]                rsp_result,
   output logic [lnu_pkg::ADDR_W-1:0]        rsp_index,
   output logic                              rsp_last,
   output logic                              rsp_status,
   input  wire logic                         csr_write,
   input  wire logic                         csr_index,
   input  wire logic [31:0]                  csr_data
);

   // sequencer codes
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SUM  = 4'd1;   // sum pass
   localparam logic [3:0] S_MDIV = 4'd2;   // mean division
   localparam logic [3:0] S_VAR  = 4'd3;   // squared deviation pass
   localparam logic [3:0] S_VDIV = 4'd4;   // variance division
   localparam logic [3:0] S_ROOT = 4'd5;   // inverse square root
   localparam logic [3:0] S_DRN1 = 4'd6;   // buffer data back, deviation times inverse
   localparam logic [3:0] S_DRN2 = 4'd7;   // round and clamp t
   localparam logic [3:0] S_DRN3 = 4'd8;   // t times gain
   localparam logic [3:0] S_DRN4 = 4'd9;   // round, add offset, present

   localparam int AW = lnu_pkg::ADDR_W;
   localparam int LW = lnu_pkg::LEN_W;

   // configuration
   logic [LW-1:0] row_length_ff, row_length_in;
   logic [31:0]   epsilon_ff, epsilon_in;

   // control
   logic [3:0]    state_ff, state_in;
   logic [LW-1:0] load_count_ff, load_count_in;
   logic [LW-1:0] read_position_ff, read_position_in;
   logic          row_ready_ff, row_ready_in;
   logic [LW-1:0] latched_len_ff, latched_len_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic          vld1_ff, vld1_in;
   logic          vld2_ff, vld2_in;
   logic [lnu_pkg::CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [4:0]    root_bit_ff, root_bit_in;
   logic [2:0]    root_step_ff, root_step_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // row statistics
   logic signed [lnu_pkg::SUM_W-1:0] running_sum_ff, running_sum_in;
   logic signed [31:0] row_mean_ff, row_mean_in;
   logic [31:0]        inverse_deviation_ff, inverse_deviation_in;

   // datapath payload
   logic [lnu_pkg::SQ_W-1:0]  sumsq_ff, sumsq_in;
   logic [lnu_pkg::DIV_W-1:0] div_num_ff, div_num_in;
   logic [lnu_pkg::DVS_W-1:0] div_rem_ff, div_rem_in;
   logic [lnu_pkg::DVS_W-1:0] div_dvs_ff, div_dvs_in;
   logic                      mean_neg_ff, mean_neg_in;
   logic [63:0]               s_ff, s_in;
   logic [31:0]               root_x_ff, root_x_in;
   logic [63:0]               root_c_ff, root_c_in;
   logic [127:0]              root_acc_ff, root_acc_in;
   logic signed [lnu_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [31:0]        t_ff, t_in;
   logic signed [31:0]        gain_ff, gain_in;
   logic signed [31:0]        offset_ff, offset_in;
   logic signed [31:0]        rsp_result_ff, rsp_result_in;
   logic [AW-1:0]             rsp_index_ff, rsp_index_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_status_ff, rsp_status_in;

   // buffer port
   logic                      ram_wr_en;
   logic                      ram_rd_en;
   logic [AW-1:0]             ram_rd_addr;
   logic [lnu_pkg::ROW_W-1:0] ram_rd_data;

   // combinational helpers
   logic          accept;
   logic [LW-1:0] len_eff;
   logic signed [lnu_pkg::MUL_W-1:0] mul_a, mul_b;
   logic signed [31:0] rd_sample, rd_gain, rd_offset;
   logic signed [lnu_pkg::MUL_W-1:0] rd_dev;
   logic [lnu_pkg::DVS_W:0]   div_trial;
   logic                      div_ge;
   logic [31:0]               root_cand;
   logic                      root_fits;
   logic [LW:0]               next_pos;
   logic                      drain_last;
   logic [LW-1:0]             load_next;
   logic signed [44:0]        mean_num;
   logic [44:0]               mean_mag;
   logic signed [46:0]        mean_q;
   logic signed [lnu_pkg::WIDE_W-1:0] out_sum;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // row length as used: zero acts as one, oversize clamps
   always_comb begin
      if (row_length_ff == '0) begin
         len_eff = LW'(1);
      end else if (row_length_ff > LW'(lnu_pkg::MAX_LEN)) begin
         len_eff = LW'(lnu_pkg::MAX_LEN);
      end else begin
         len_eff = row_length_ff;
      end
   end

   assign rd_sample = ram_rd_data[31:0];
   assign rd_gain   = ram_rd_data[63:32];
   assign rd_offset = ram_rd_data[95:64];
   assign rd_dev    = $signed({rd_sample[31], rd_sample}) - $signed({row_mean_ff[31], row_mean_ff});

   // one restoring-division step
   assign div_trial = {div_rem_ff, div_num_ff[lnu_pkg::DIV_W-1]};
   assign div_ge    = (div_trial >= {1'b0, div_dvs_ff});

   // root candidate fits when cand^2 * s <= 2^64
   assign root_cand = root_x_ff | (32'd1 << root_bit_ff);
   assign root_fits = (root_acc_ff[127:65] == '0)
                      && (!root_acc_ff[64] || (root_acc_ff[63:0] == '0));

   assign next_pos   = {1'b0, read_position_ff} + (LW+1)'(1);
   assign drain_last = (next_pos >= {1'b0, latched_len_ff});
   assign load_next  = (load_count_ff < len_eff) ? load_count_ff + LW'(1) : load_count_ff;

   assign mean_num = 45'(running_sum_ff) * 45'sd2 + $signed(45'(len_eff));
   assign mean_mag = mean_num[44] ? 45'(-mean_num) : 45'(mean_num);

   always_comb begin
      if (mean_neg_ff) begin
         if (div_rem_ff != '0) begin
            mean_q = -$signed({2'b00, div_num_ff[44:0]}) - 47'sd1;
         end else begin
            mean_q = -$signed({2'b00, div_num_ff[44:0]});
         end
      end else begin
         mean_q = $signed({2'b00, div_num_ff[44:0]});
      end
   end

   assign out_sum = lnu_pkg::WIDE_W'(lnu_pkg::round16(prod_ff))
                    + lnu_pkg::WIDE_W'(offset_ff);

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_VAR: begin
            mul_a = rd_dev;
            mul_b = rd_dev;
         end
         S_ROOT: begin
            case (root_step_ff)
               3'd0: begin
                  mul_a = $signed({1'b0, root_cand});
                  mul_b = $signed({1'b0, root_cand});
               end
               3'd2: begin
                  mul_a = $signed({1'b0, root_c_ff[31:0]});
                  mul_b = $signed({1'b0, s_ff[31:0]});
               end
               3'd3: begin
                  mul_a = $signed({1'b0, root_c_ff[31:0]});
                  mul_b = $signed({1'b0, s_ff[63:32]});
               end
               3'd4: begin
                  mul_a = $signed({1'b0, root_c_ff[63:32]});
                  mul_b = $signed({1'b0, s_ff[31:0]});
               end
               3'd5: begin
                  mul_a = $signed({1'b0, root_c_ff[63:32]});
                  mul_b = $signed({1'b0, s_ff[63:32]});
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         S_DRN1: begin
            mul_a = rd_dev;
            mul_b = $signed({1'b0, inverse_deviation_ff});
         end
         S_DRN3: begin
            mul_a = $signed({t_ff[31], t_ff});
            mul_b = $signed({gain_ff[31], gain_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // buffer read address: drain position from idle, pass position otherwise
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = pos_ff[AW-1:0];
      if (state_ff == S_IDLE) begin
         ram_rd_addr = read_position_ff[AW-1:0];
         ram_rd_en   = accept && (req_func == lnu_pkg::FUNC_DRAIN) && row_ready_ff;
         ram_wr_en   = accept && (req_func == lnu_pkg::FUNC_LOAD) && !row_ready_ff
                       && (load_count_ff < len_eff);
      end else if ((state_ff == S_SUM) || (state_ff == S_VAR)) begin
         ram_rd_en = (pos_ff < latched_len_ff);
      end
   end

   // next state and next values
   always_comb begin
      state_in             = state_ff;
      row_length_in        = row_length_ff;
      epsilon_in           = epsilon_ff;
      load_count_in        = load_count_ff;
      read_position_in     = read_position_ff;
      row_ready_in         = row_ready_ff;
      latched_len_in       = latched_len_ff;
      pos_in               = pos_ff;
      vld1_in              = 1'b0;
      vld2_in              = 1'b0;
      div_cnt_in           = div_cnt_ff;
      root_bit_in          = root_bit_ff;
      root_step_in         = root_step_ff;
      rsp_valid_in         = 1'b0;
      running_sum_in       = running_sum_ff;
      row_mean_in          = row_mean_ff;
      inverse_deviation_in = inverse_deviation_ff;
      sumsq_in             = sumsq_ff;
      div_num_in           = div_num_ff;
      div_rem_in           = div_rem_ff;
      div_dvs_in           = div_dvs_ff;
      mean_neg_in          = mean_neg_ff;
      s_in                 = s_ff;
      root_x_in            = root_x_ff;
      root_c_in            = root_c_ff;
      root_acc_in          = root_acc_ff;
      t_in                 = t_ff;
      gain_in              = gain_ff;
      offset_in            = offset_ff;
      rsp_result_in        = rsp_result_ff;
      rsp_index_in         = rsp_index_ff;
      rsp_last_in          = rsp_last_ff;
      rsp_status_in        = rsp_status_ff;

      // configuration writes
      if (csr_write) begin
         if (csr_index == lnu_pkg::CSR_ROW_LENGTH) begin
            row_length_in = csr_data[LW-1:0];
         end else begin
            epsilon_in = csr_data;
         end
      end

      // bit-serial divider, shared by mean and variance
      if ((state_ff == S_MDIV) || (state_ff == S_VDIV)) begin
         if (div_cnt_ff != '0) begin
            div_num_in = {div_num_ff[lnu_pkg::DIV_W-2:0], div_ge};
            div_rem_in = div_ge ? lnu_pkg::DVS_W'(div_trial - {1'b0, div_dvs_ff})
                                : div_trial[lnu_pkg::DVS_W-1:0];
            div_cnt_in = div_cnt_ff - lnu_pkg::CNT_W'(1);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_func == lnu_pkg::FUNC_LOAD) begin
                  if (!row_ready_ff) begin
                     load_count_in = load_next;
                     if (load_next >= len_eff) begin
                        // row complete: start the statistics
                        latched_len_in = len_eff;
                        pos_in         = '0;
                        running_sum_in = '0;
                        state_in       = S_SUM;
                     end
                  end
               end else if (row_ready_ff) begin
                  state_in = S_DRN1;
               end else begin
                  // drain before the row is ready
                  rsp_valid_in  = 1'b1;
                  rsp_result_in = '0;
                  rsp_index_in  = '0;
                  rsp_last_in   = 1'b0;
                  rsp_status_in = lnu_pkg::STATUS_NOT_READY;
               end
            end
         end

         S_SUM: begin
            if (pos_ff < latched_len_ff) begin
               pos_in  = pos_ff + LW'(1);
               vld1_in = 1'b1;
            end
            if (vld1_ff) begin
               running_sum_in = running_sum_ff + lnu_pkg::SUM_W'(rd_sample);
            end
            if ((pos_ff >= latched_len_ff) && !vld1_ff) begin
               // mean = floor((2*sum + L) / 2L)
               mean_neg_in = mean_num[44];
               div_num_in  = lnu_pkg::DIV_W'(mean_mag);
               div_rem_in  = '0;
               div_dvs_in  = {latched_len_ff, 1'b0};
               div_cnt_in  = lnu_pkg::CNT_W'(lnu_pkg::DIV_W);
               state_in    = S_MDIV;
            end
         end

         S_MDIV: begin
            if (div_cnt_ff == '0) begin
               row_mean_in = lnu_pkg::sat32(lnu_pkg::WIDE_W'(mean_q));
               pos_in      = '0;
               sumsq_in    = '0;
               state_in    = S_VAR;
            end
         end

         S_VAR: begin
            if (pos_ff < latched_len_ff) begin
               pos_in  = pos_ff + LW'(1);
               vld1_in = 1'b1;
            end
            vld2_in = vld1_ff;
            if (vld2_ff) begin
               sumsq_in = sumsq_ff + lnu_pkg::SQ_W'(prod_ff[63:0]);
            end
            if ((pos_ff >= latched_len_ff) && !vld1_ff && !vld2_ff) begin
               div_num_in = sumsq_ff;
               div_rem_in = '0;
               div_dvs_in = {1'b0, latched_len_ff};
               div_cnt_in = lnu_pkg::CNT_W'(lnu_pkg::DIV_W);
               state_in   = S_VDIV;
            end
         end

         S_VDIV: begin
            if (div_cnt_ff == '0) begin
               s_in         = div_num_ff[63:0] + 64'(epsilon_ff);
               root_x_in    = '0;
               root_bit_in  = 5'd31;
               root_step_in = '0;
               state_in     = S_ROOT;
            end
         end

         S_ROOT: begin
            root_step_in = root_step_ff + 3'd1;
            case (root_step_ff)
               3'd1: begin
                  root_c_in   = prod_ff[63:0];
                  root_acc_in = '0;
               end
               3'd3: root_acc_in = root_acc_ff + 128'(prod_ff[63:0]);
               3'd4: root_acc_in = root_acc_ff + (128'(prod_ff[63:0]) << 32);
               3'd5: root_acc_in = root_acc_ff + (128'(prod_ff[63:0]) << 32);
               3'd6: root_acc_in = root_acc_ff + (128'(prod_ff[63:0]) << 64);
               3'd7: begin
                  if (root_fits) begin
                     root_x_in = root_cand;
                  end
                  if (root_bit_ff == '0) begin
                     inverse_deviation_in = root_fits ? root_cand : root_x_ff;
                     read_position_in     = '0;
                     row_ready_in         = 1'b1;
                     state_in             = S_IDLE;
                  end else begin
                     root_bit_in = root_bit_ff - 5'd1;
                  end
               end
               default: begin
                  root_acc_in = root_acc_ff;
               end
            endcase
         end

         S_DRN1: begin
            gain_in   = rd_gain;
            offset_in = rd_offset;
            state_in  = S_DRN2;
         end

         S_DRN2: begin
            t_in     = lnu_pkg::sat32(lnu_pkg::WIDE_W'(lnu_pkg::round16(prod_ff)));
            state_in = S_DRN3;
         end

         S_DRN3: begin
            state_in = S_DRN4;
         end

         S_DRN4: begin
            rsp_valid_in  = 1'b1;
            rsp_result_in = lnu_pkg::sat32(out_sum);
            rsp_index_in  = read_position_ff[AW-1:0];
            rsp_last_in   = drain_last;
            rsp_status_in = lnu_pkg::STATUS_OK;
            if (drain_last) begin
               // row done: open the buffer for the next row
               load_count_in    = '0;
               running_sum_in   = '0;
               read_position_in = '0;
               row_ready_in     = 1'b0;
            end else begin
               read_position_in = next_pos[LW-1:0];
            end
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= S_IDLE;
         row_length_ff        <= lnu_pkg::ROW_LENGTH_RESET;
         epsilon_ff           <= lnu_pkg::EPSILON_RESET;
         load_count_ff        <= '0;
         read_position_ff     <= '0;
         row_ready_ff         <= 1'b0;
         latched_len_ff       <= LW'(1);
         vld1_ff              <= 1'b0;
         vld2_ff              <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         running_sum_ff       <= '0;
         row_mean_ff          <= '0;
         inverse_deviation_ff <= '0;
      end else begin
         state_ff             <= state_in;
         row_length_ff        <= row_length_in;
         epsilon_ff           <= epsilon_in;
         load_count_ff        <= load_count_in;
         read_position_ff     <= read_position_in;
         row_ready_ff         <= row_ready_in;
         latched_len_ff       <= latched_len_in;
         vld1_ff              <= vld1_in;
         vld2_ff              <= vld2_in;
         rsp_valid_ff         <= rsp_valid_in;
         running_sum_ff       <= running_sum_in;
         row_mean_ff          <= row_mean_in;
         inverse_deviation_ff <= inverse_deviation_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      div_cnt_ff    <= div_cnt_in;
      root_bit_ff   <= root_bit_in;
      root_step_ff  <= root_step_in;
      sumsq_ff      <= sumsq_in;
      div_num_ff    <= div_num_in;
      div_rem_ff    <= div_rem_in;
      div_dvs_ff    <= div_dvs_in;
      mean_neg_ff   <= mean_neg_in;
      s_ff          <= s_in;
      root_x_ff     <= root_x_in;
      root_c_ff     <= root_c_in;
      root_acc_ff   <= root_acc_in;
      prod_ff       <= prod_in;
      t_ff          <= t_in;
      gain_ff       <= gain_in;
      offset_ff     <= offset_in;
      rsp_result_ff <= rsp_result_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   // sample, gain and offset side by side, one row per element
   lnu_ram #(
      .WIDTH (lnu_pkg::ROW_W),
      .DEPTH (lnu_pkg::MAX_LEN)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (load_count_ff[AW-1:0]),
      .wr_data ({req_offset, req_gain, req_sample}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

>>> design/lnu_checker.sv
`default_nettype none
`include "layer_normalization_unit_macros.svh"

module lnu_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic                  req_func,
   input wire logic signed [31:0]    req_sample,
   input wire logic signed [31:0]    req_gain,
   input wire logic signed [31:0]    req_offset,
   input wire logic                  rsp_valid,
   input wire logic signed [31:0]    rsp_result,
   input wire logic [lnu_pkg::ADDR_W-1:0] rsp_index,
   input wire logic                  rsp_last,
   input wire logic                  rsp_status,
   input wire logic                  csr_write,
   input wire logic                  csr_index,
   input wire logic [31:0]           csr_data
);

   logic load_accept;

   assign load_accept = start && !busy && (req_func == lnu_pkg::FUNC_LOAD);

   // a not-ready answer carries no element
   `LNU_ASSERT_IMPL(a_not_ready_empty, rsp_valid && (rsp_status == lnu_pkg::STATUS_NOT_READY), (rsp_result == 32'sd0) && (rsp_index == '0) && !rsp_last)
   // the final element is always a real result
   `LNU_ASSERT_IMPL(a_last_valid, rsp_valid && rsp_last, rsp_status == lnu_pkg::STATUS_OK)
   // a real result comes out of a busy drain
   `LNU_ASSERT_IMPL(a_result_after_busy, rsp_valid && (rsp_status == lnu_pkg::STATUS_OK), $past(busy))
   // a load transfer never produces a result
   `LNU_ASSERT_NEXT(a_load_silent, load_accept, !rsp_valid)
   // register writes only while the block is idle
   `LNU_ASSERT_IMPL(a_csr_idle, csr_write, !busy)

endmodule

bind layer_normalization_unit lnu_checker u_lnu_checker (.*);

`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lnu_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   // one normalized element as it leaves the block
   typedef struct {
      logic signed [31:0] result;
      logic [9:0]         index;
      logic               last;
      logic               status;
   } norm_out_type;

   // directed stimulus: either a request or a register write
   typedef enum logic {ROW_REQ, ROW_CSR} dir_kind_type;

   typedef struct {
      dir_kind_type kind;
      logic         func;      // or csr index for ROW_CSR
      logic [31:0]  sample;    // or csr data for ROW_CSR
      logic [31:0]  gain;
      logic [31:0]  offset;
      bit           typed;     // expected result given in the row
      norm_out_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_func = FUNC_LOAD;
   logic signed [31:0] req_sample = '0;
   logic signed [31:0] req_gain = '0;
   logic signed [31:0] req_offset = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_result;
   logic [ADDR_W-1:0] rsp_index;
   logic rsp_last;
   logic rsp_status;
   logic csr_write = 1'b0;
   logic csr_index = CSR_ROW_LENGTH;
   logic [31:0] csr_data = '0;

   layer_normalization_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_func   (req_func),
      .req_sample (req_sample),
      .req_gain   (req_gain),
      .req_offset (req_offset),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result),
      .rsp_index  (rsp_index),
      .rsp_last   (rsp_last),
      .rsp_status (rsp_status),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // predictor state: own copy of the row buffers and statistics
   // ---------------------------------------------------------------
   logic [31:0]        row_samples [MAX_LEN];
   logic [31:0]        row_gains   [MAX_LEN];
   logic [31:0]        row_offsets [MAX_LEN];
   int unsigned        fill_count;
   logic signed [31:0] row_mean_q;
   logic [31:0]        inv_dev_q;
   int unsigned        drain_pos;
   bit                 row_is_ready;
   int unsigned        row_len_latched;
   logic [10:0]        cfg_row_length;
   logic [31:0]        cfg_epsilon;

   norm_out_type pending_outputs[$];
   int        fail_count;
   int        xfer_count;
   int        rsp_count;
   int        not_ready_count;
   int        row_count;

   function automatic longint clamp_word(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // magnitude shifted right 16, rounded half away from zero, sign restored
   function automatic longint shift16_round(input logic [127:0] mag, input bit neg);
      logic [127:0] r;
      r = (mag + 128'd32768) >> 16;
      return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
   endfunction

   function automatic int unsigned active_length();
      if (cfg_row_length == 0) return 1;
      if (cfg_row_length > MAX_LEN) return MAX_LEN;
      return cfg_row_length;
   endfunction

   // mean, biased variance and inverse deviation of the first len entries
   task automatic compute_row_stats(input int unsigned len);
      longint       sum;
      longint       num;
      longint       den;
      longint       q;
      longint       d;
      logic [79:0]  dmag;
      logic [79:0]  sq_acc;
      logic [79:0]  spread;
      logic [159:0] cand;
      logic [159:0] prod;
      logic [63:0]  x;
      sum = 0;
      for (int i = 0; i < len; i++) sum += longint'($signed(row_samples[i]));
      num = 2 * sum + longint'(len);
      den = 2 * longint'(len);
      q = num / den;
      if ((num % den) != 0 && num < 0) q--;
      row_mean_q = 32'(clamp_word(q));
      sq_acc = '0;
      for (int i = 0; i < len; i++) begin
         d = longint'($signed(row_samples[i])) - longint'(row_mean_q);
         dmag = (d < 0) ? 80'(-d) : 80'(d);
         sq_acc += dmag * dmag;
      end
      spread = sq_acc / 80'(len) + 80'(cfg_epsilon);
      x = '0;
      for (int b = 31; b >= 0; b--) begin
         cand = 160'(x | (64'd1 << b));
         prod = cand * cand * 160'(spread);
         if (prod <= (160'd1 << 64)) x = cand[63:0];
      end
      inv_dev_q = x[31:0];
      row_len_latched = len;
      drain_pos = 0;
      row_is_ready = 1'b1;
      row_count++;
   endtask

   // advance the predictor by one request; has_out set when a result follows
   task automatic predict_request(input logic func, input logic [31:0] smp,
                                  input logic [31:0] gn, input logic [31:0] ofs,
                                  output bit has_out, output norm_out_type o);
      int unsigned len;
      int unsigned i;
      longint      d;
      longint      t;
      longint      g;
      longint      p;
      logic [127:0] m;
      len = active_length();
      has_out = 1'b0;
      o = '{result: '0, index: '0, last: 1'b0, status: STATUS_OK};
      if (func == FUNC_LOAD) begin
         if (row_is_ready) return;
         if (fill_count < len) begin
            row_samples[fill_count] = smp;
            row_gains[fill_count] = gn;
            row_offsets[fill_count] = ofs;
            fill_count++;
         end
         if (fill_count >= len) compute_row_stats(len);
         return;
      end
      has_out = 1'b1;
      if (!row_is_ready) begin
         o.status = STATUS_NOT_READY;
         return;
      end
      i = (drain_pos >= MAX_LEN) ? MAX_LEN - 1 : drain_pos;
      d = longint'($signed(row_samples[i])) - longint'(row_mean_q);
      m = (d < 0) ? 128'(-d) : 128'(d);
      t = clamp_word(shift16_round(m * 128'(inv_dev_q), d < 0));
      g = longint'($signed(row_gains[i]));
      m = 128'((t < 0) ? -t : t) * 128'((g < 0) ? -g : g);
      p = shift16_round(m, (t < 0) != (g < 0));
      o.result = 32'(clamp_word(p + longint'($signed(row_offsets[i]))));
      o.index = 10'(i);
      o.last = (i + 1 >= row_len_latched);
      drain_pos = i + 1;
      if (o.last) begin
         fill_count = 0;
         drain_pos = 0;
         row_is_ready = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------
   // result checker: the receiver never stalls, one compare per strobe
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      norm_out_type want;
      if (!reset && rsp_valid) begin
         rsp_count++;
         if (pending_outputs.size() == 0) begin
            $display("%0t: unexpected result transfer result=%h index=%0d last=%b status=%b",
                     $time, rsp_result, rsp_index, rsp_last, rsp_status);
            fail_count++;
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %b actual %b", $time, want.status, rsp_status);
               fail_count++;
            end
            if (rsp_result !== want.result) begin
               $display("%0t: result expected %h actual %h", $time, want.result, rsp_result);
               fail_count++;
            end
            if (rsp_index !== want.index) begin
               $display("%0t: index expected %0d actual %0d", $time, want.index, rsp_index);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // watchdog: cycles with no transfer on either side
   int quiet_cycles;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, pending_outputs.size());
            $display("layer_normalization_unit verification failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus side
   // ---------------------------------------------------------------
   bit no_gaps;

   // one request transfer; a gap of idle cycles may come first
   task automatic send_request(input logic func, input logic [31:0] smp,
                               input logic [31:0] gn, input logic [31:0] ofs,
                               input bit typed, input norm_out_type want);
      bit           has_out;
      norm_out_type pred;
      if (!no_gaps && $urandom_range(0, 99) < 15) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= func;
      req_sample <= smp;
      req_gain <= gn;
      req_offset <= ofs;
      do @(posedge clock); while (busy);
      // transfer happens at this edge
      xfer_count++;
      predict_request(func, smp, gn, ofs, has_out, pred);
      if (has_out) begin
         if (pred.status == STATUS_NOT_READY) not_ready_count++;
         pending_outputs.push_back(typed ? want : pred);
      end
   endtask

   // block idle: nothing outstanding and the statistics passes finished
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_outputs.size() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] data);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      if (idx == CSR_ROW_LENGTH) cfg_row_length = data[10:0];
      else cfg_epsilon = data;
      csr_write <= 1'b0;
   endtask

   // mix of extremes, small deviations and full-range words
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($urandom_range(0, 32'h3ffff)) - 32'h20000;
         3: return 32'($urandom_range(0, 32'h7ffff)) - 32'h40000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_load();
      norm_out_type none;
      none = '{result: '0, index: '0, last: 1'b0, status: STATUS_OK};
      send_request(FUNC_LOAD, pick_word(), pick_word(), pick_word(), 1'b0, none);
   endtask

   task automatic send_drain();
      norm_out_type none;
      none = '{result: '0, index: '0, last: 1'b0, status: STATUS_OK};
      send_request(FUNC_DRAIN, $urandom, $urandom, $urandom, 1'b0, none);
   endtask

   localparam norm_out_type NOT_READY_OUT = '{result: '0, index: '0, last: 1'b0,
                                              status: STATUS_NOT_READY};
   localparam norm_out_type NO_OUT = '{result: '0, index: '0, last: 1'b0, status: STATUS_OK};

   // directed rows; typed results only where obvious
   dir_row_type directed [] = '{
      // drain straight after reset
      '{ROW_REQ, FUNC_DRAIN, 32'h0, 32'h0, 32'h0, 1'b1, NOT_READY_OUT},
      '{ROW_CSR, CSR_ROW_LENGTH, 32'd1, 32'h0, 32'h0, 1'b0, NO_OUT},
      '{ROW_CSR, CSR_EPSILON, 32'h0, 32'h0, 32'h0, 1'b0, NO_OUT},
      // single element row: zero deviation, result is the offset
      '{ROW_REQ, FUNC_LOAD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, NO_OUT},
      // load on a ready row is dropped
      '{ROW_REQ, FUNC_LOAD, 32'h12345678, 32'h1, 32'h1, 1'b0, NO_OUT},
      '{ROW_REQ, FUNC_DRAIN, 32'h0, 32'h0, 32'h0, 1'b1,
        '{result: 32'sh7fffffff, index: 10'd0, last: 1'b1, status: STATUS_OK}},
      '{ROW_REQ, FUNC_DRAIN, 32'h0, 32'h0, 32'h0, 1'b1, NOT_READY_OUT},
      // two extremes, widest spread
      '{ROW_CSR, CSR_ROW_LENGTH, 32'd2, 32'h0, 32'h0, 1'b0, NO_OUT},
      '{ROW_CSR, CSR_EPSILON, 32'hffffffff, 32'h0, 32'h0, 1'b0, NO_OUT},
      '{ROW_REQ, FUNC_LOAD, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0, NO_OUT},
      '{ROW_REQ, FUNC_DRAIN, 32'h0, 32'h0, 32'h0, 1'b1, NOT_READY_OUT},
      '{ROW_REQ, FUNC_LOAD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, NO_OUT},
      '{ROW_REQ, FUNC_DRAIN, 32'h0, 32'h0, 32'h0, 1'b0, NO_OUT},
      '{ROW_REQ, FUNC_DRAIN, 32'h0, 32'h0, 32'h0, 1'b0, NO_OUT},
      // zero length acts as one
      '{ROW_CSR, CSR_ROW_LENGTH, 32'd0, 32'h0, 32'h0, 1'b0, NO_OUT},
      '{ROW_CSR, CSR_EPSILON, 32'd1, 32'h0, 32'h0, 1'b0, NO_OUT},
      '{ROW_REQ, FUNC_LOAD, 32'h00010000, 32'h80000000, 32'h00000000, 1'b0, NO_OUT},
      '{ROW_REQ, FUNC_DRAIN, 32'h0, 32'h0, 32'h0, 1'b1,
        '{result: 32'sh0, index: 10'd0, last: 1'b1, status: STATUS_OK}},
      // length lowered below the fill level
      '{ROW_CSR, CSR_ROW_LENGTH, 32'd4, 32'h0, 32'h0, 1'b0, NO_OUT},
      '{ROW_REQ, FUNC_LOAD, 32'hfffe0000, 32'h00020000, 32'hffff0000, 1'b0, NO_OUT},
      '{ROW_REQ, FUNC_LOAD, 32'h00030000, 32'h00010000, 32'h00008000, 1'b0, NO_OUT},
      '{ROW_CSR, CSR_ROW_LENGTH, 32'd1, 32'h0, 32'h0, 1'b0, NO_OUT},
      '{ROW_REQ, FUNC_LOAD, 32'h00050000, 32'h00010000, 32'h00000000, 1'b0, NO_OUT},
      '{ROW_REQ, FUNC_DRAIN, 32'h0, 32'h0, 32'h0, 1'b0, NO_OUT}
   };

   initial begin
      int unsigned len;
      int unsigned k;
      int unsigned phase;
      int unsigned part;
      fail_count = 0;
      xfer_count = 0;
      rsp_count = 0;
      not_ready_count = 0;
      row_count = 0;
      no_gaps = 1'b0;
      fill_count = 0;
      row_mean_q = '0;
      inv_dev_q = '0;
      drain_pos = 0;
      row_is_ready = 1'b0;
      row_len_latched = 1;
      cfg_row_length = ROW_LENGTH_RESET;
      cfg_epsilon = EPSILON_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[r]) begin
         if (directed[r].kind == ROW_CSR) begin
            write_csr(directed[r].func, directed[r].sample);
         end else begin
            send_request(directed[r].func, directed[r].sample, directed[r].gain,
                         directed[r].offset, directed[r].typed, directed[r].want);
         end
      end

      // random rows: mostly well-formed load/drain sequences
      phase = 0;
      while (xfer_count < 420 || phase < 4) begin
         no_gaps = (xfer_count >= 150 && xfer_count < 300);
         wait_idle();
         if (phase == 2) begin
            // all bits set, clamped to full size, then shrunk while partly loaded
            write_csr(CSR_ROW_LENGTH, 32'd2047);
         end else begin
            case ($urandom_range(0, 9))
               0: write_csr(CSR_ROW_LENGTH, 32'd1);
               1: write_csr(CSR_ROW_LENGTH, 32'd3);
               default: write_csr(CSR_ROW_LENGTH, $urandom_range(2, 24));
            endcase
         end
         case ($urandom_range(0, 3))
            0: write_csr(CSR_EPSILON, 32'h0);
            1: write_csr(CSR_EPSILON, 32'hffffffff);
            default: write_csr(CSR_EPSILON, $urandom);
         endcase
         len = active_length();
         if ($urandom_range(0, 4) == 0) send_drain();     // early drain
         // occasionally shrink the row while partly loaded
         if (phase == 2 || (len >= 4 && $urandom_range(0, 7) == 0)) begin
            part = (len / 2 > 12) ? 12 : len / 2;
            for (k = 0; k < part; k++) send_load();
            write_csr(CSR_ROW_LENGTH, $urandom_range(1, part));
            send_load();
         end else begin
            for (k = 0; k < len; k++) begin
               send_load();
               if (!row_is_ready && $urandom_range(0, 19) == 0) send_drain();
            end
         end
         for (k = 0; k < row_len_latched; k++) begin
            // length change mid-drain must not matter
            if (k == row_len_latched / 2 && $urandom_range(0, 7) == 0)
               write_csr(CSR_ROW_LENGTH, $urandom_range(1, 30));
            if ($urandom_range(0, 9) == 0) send_load();   // dropped while draining
            send_drain();
         end
         if ($urandom_range(0, 3) == 0) send_drain();     // past the end
         phase++;
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("covered %0d request transfers over %0d rows, %0d results checked",
               xfer_count, row_count, rsp_count);
      $display("%0d not-ready drains, lengths 0 to 2047, epsilon extremes included",
               not_ready_count);
      if (fail_count == 0 && pending_outputs.size() == 0) begin
         $display("layer_normalization_unit verification clean");
      end else begin
         $display("layer_normalization_unit verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> layer_normalization_unit.f
+incdir+design
design/lnu_pkg.sv
design/lnu_ram.sv
design/layer_normalization_unit.sv
design/lnu_checker.sv
dv/tb_top.sv
